>>> sv/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared constants, types and register codes for the half-band decimator.
// ----------------------------------------------------------------------------
package hbd_pkg;

    // default sample width
    localparam int DATA_WIDTH_DEF = 16;

    // filter geometry
    localparam int NTAPS  = 27;
    localparam int CENTRE = (NTAPS - 1) / 2;
    localparam int NPAIR  = (CENTRE + 1) / 2;
    localparam int NCOEF  = NPAIR + 1;

    // coefficient and configuration port widths
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 4;

    typedef logic signed [COEF_W-1:0] coef_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_ZERO   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_FOUR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_SIX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_EIGHT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TEN    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TWELVE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_CENTRE = 4'd7;

    // coefficient slot positions, centre tap last
    localparam int SLOT_CENTRE = NCOEF - 1;

    // coefficient values after reset, in register order
    localparam coef_t COEF_RESET [NCOEF] = '{
        16'sd33, -16'sd158, 16'sd491, -16'sd1214,
        16'sd2674, -16'sd5942, 16'sd20503, 16'sd32767
    };

    // per-stage load enables of the result pipeline
    typedef struct packed {
        logic p1;
        logic p2;
        logic p3;
        logic p4;
        logic po;
    } stage_en_t;

endpackage

>>> sv/hbd_coef_regs.sv
// ----------------------------------------------------------------------------
// hbd_coef_regs
// Coefficient register file written through the configuration port.
// ----------------------------------------------------------------------------
module hbd_coef_regs
    import hbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output coef_t                coefs [NCOEF]
);

    coef_t coef_reg [NCOEF];

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                coef_reg[k] <= COEF_RESET[k];
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TAP_ZERO:   coef_reg[0] <= $signed(cfg_data);
                REG_TAP_TWO:    coef_reg[1] <= $signed(cfg_data);
                REG_TAP_FOUR:   coef_reg[2] <= $signed(cfg_data);
                REG_TAP_SIX:    coef_reg[3] <= $signed(cfg_data);
                REG_TAP_EIGHT:  coef_reg[4] <= $signed(cfg_data);
                REG_TAP_TEN:    coef_reg[5] <= $signed(cfg_data);
                REG_TAP_TWELVE: coef_reg[6] <= $signed(cfg_data);
                REG_TAP_CENTRE: coef_reg[SLOT_CENTRE] <= $signed(cfg_data);
                default:        ;
            endcase
        end
    end

    assign coefs = coef_reg;

endmodule

>>> sv/hbd_delay_line.sv
// ----------------------------------------------------------------------------
// hbd_delay_line
// Sample delay line, decimation phase and registered pre-adds of mirror taps.
// ----------------------------------------------------------------------------
module hbd_delay_line
    import hbd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic signed [DATA_WIDTH-1:0] sample,
    output logic                         phase,
    output logic                         load,
    output logic signed [DATA_WIDTH:0]   pre [NCOEF]
);

    // positions 0..NTAPS-2 of the line; the last position is never read again
    logic signed [DATA_WIDTH-1:0] line_reg [NTAPS-1];
    logic                         phase_reg;
    logic signed [DATA_WIDTH:0]   pre_reg  [NCOEF];
    logic signed [DATA_WIDTH:0]   pre_next [NCOEF];
    logic signed [DATA_WIDTH-1:0] tap_next [NTAPS];

    // line contents once the current word has shifted in
    always_comb
    begin
        tap_next[0] = sample;
        for (int i = 1; i < NTAPS; i++)
        begin
            tap_next[i] = line_reg[i-1];
        end
    end

    // mirror pair pre-adds, centre tap sign extended into the last slot
    always_comb
    begin
        for (int k = 0; k < NPAIR; k++)
        begin
            pre_next[k] = (DATA_WIDTH+1)'(tap_next[2*k])
                        + (DATA_WIDTH+1)'(tap_next[NTAPS-1-2*k]);
        end
        pre_next[SLOT_CENTRE] = (DATA_WIDTH+1)'(tap_next[CENTRE]);
    end

    // shift register and phase, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NTAPS-1; i++)
            begin
                line_reg[i] <= '0;
            end
            phase_reg <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NTAPS-1; i++)
            begin
                line_reg[i] <= tap_next[i];
            end
            phase_reg <= ~phase_reg;
        end
    end

    // pre-add stage loads on words that give a result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pre_reg <= pre_next;
        end
    end

    assign load  = accept & phase_reg;
    assign phase = phase_reg;
    assign pre   = pre_reg;

endmodule

>>> sv/hbd_datapath.sv
// ----------------------------------------------------------------------------
// hbd_datapath
// One real channel: coefficient products, adder tree, rounding, saturation.
// ----------------------------------------------------------------------------
module hbd_datapath
    import hbd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  stage_en_t                    en,
    input  logic signed [DATA_WIDTH:0]   pre [NCOEF],
    input  coef_t                        coefs [NCOEF],
    output logic signed [DATA_WIDTH-1:0] result
);

    localparam int PROD_W = DATA_WIDTH + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SUM_W  = ACC_W + 1;
    localparam int NHALF  = NCOEF / 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic signed [PROD_W-1:0]     prod_reg [NCOEF];
    logic signed [ACC_W-1:0]      half_reg [NHALF];
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_next;
    logic signed [SUM_W-1:0]      rnd;
    logic signed [DATA_WIDTH-1:0] sat_next;
    logic signed [DATA_WIDTH-1:0] result_reg;

    // products of pre-added taps and coefficients
    always_ff @(posedge clk)
    begin
        if (en.p2)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                prod_reg[k] <= PROD_W'(pre[k]) * PROD_W'(coefs[k]);
            end
        end
    end

    // first adder level, neighbor products
    always_ff @(posedge clk)
    begin
        if (en.p3)
        begin
            for (int j = 0; j < NHALF; j++)
            begin
                half_reg[j] <= ACC_W'(prod_reg[2*j]) + ACC_W'(prod_reg[2*j+1]);
            end
        end
    end

    // final sum of the partial sums
    always_comb
    begin
        acc_next = '0;
        for (int j = 0; j < NHALF; j++)
        begin
            acc_next = acc_next + half_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.p4)
        begin
            acc_reg <= acc_next;
        end
    end

    // halve with rounding half up, then clip to the sample range
    always_comb
    begin
        rnd = (SUM_W'(acc_reg) + SUM_W'(1)) >>> 1;
        if (rnd > SAT_HI)
        begin
            sat_next = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (rnd < SAT_LO)
        begin
            sat_next = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            sat_next = rnd[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.po)
        begin
            result_reg <= sat_next;
        end
    end

    assign result = result_reg;

endmodule

>>> sv/halfband_fir_decimate_by2_top.sv
// ----------------------------------------------------------------------------
// halfband_fir_decimate_by2_top
// 27-tap half-band FIR decimator by two for complex samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    sample_re, sample_im
//  output    out        out_valid / out_ready  out_re, out_im
//  config    in         cfg_wr_en              cfg_index, cfg_data
//
//  one input word per cycle while in_ready is high; every second accepted word gives one result word
//  each result passes the pre-add, multiply, two adder and round/saturate
//  stages in that order on its way to out_valid
//  reset clears the delay line, the phase and all stage valids at once
//  each full stage holds while the next one holds; in_ready drops only when all
//  stages and the output register are full and the word would give a result
// ----------------------------------------------------------------------------
module halfband_fir_decimate_by2_top
    import hbd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] sample_re,
    input  logic signed [DATA_WIDTH-1:0] sample_im,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] out_re,
    output logic signed [DATA_WIDTH-1:0] out_im,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COEF_W-1:0]            cfg_data
);

    coef_t                      coefs [NCOEF];
    stage_en_t                  en;
    logic                       accept;
    logic                       phase_re;
    logic                       phase_im;
    logic                       load_re;
    logic                       load_im;
    logic signed [DATA_WIDTH:0] pre_re [NCOEF];
    logic signed [DATA_WIDTH:0] pre_im [NCOEF];
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       v4_reg;
    logic                       vo_reg;

    // stage enables, a stage moves when empty or when its successor moves
    always_comb
    begin
        en.po = ~vo_reg | out_ready;
        en.p4 = ~v4_reg | en.po;
        en.p3 = ~v3_reg | en.p4;
        en.p2 = ~v2_reg | en.p3;
        en.p1 = ~v1_reg | en.p2;
    end

    // words that give no result never need the pipeline; both lines step together
    assign in_ready  = en.p1 | ~(phase_re & phase_im);
    assign accept    = in_valid & in_ready;
    assign out_valid = vo_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en.p1)
            begin
                v1_reg <= load_re & load_im;
            end
            if (en.p2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.p3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.p4)
            begin
                v4_reg <= v3_reg;
            end
            if (en.po)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    hbd_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    // real part delay line and pre-adds
    hbd_delay_line #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_line_re (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample_re),
        .phase  (phase_re),
        .load   (load_re),
        .pre    (pre_re)
    );

    // imaginary part delay line, phase tracks the real one
    hbd_delay_line #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_line_im (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample_im),
        .phase  (phase_im),
        .load   (load_im),
        .pre    (pre_im)
    );

    hbd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_path_re (
        .clk    (clk),
        .en     (en),
        .pre    (pre_re),
        .coefs  (coefs),
        .result (out_re)
    );

    hbd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_path_im (
        .clk    (clk),
        .en     (en),
        .pre    (pre_im),
        .coefs  (coefs),
        .result (out_im)
    );

endmodule

>>> sv/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker
// Port-level checks of the decimator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hbd_checker
    import hbd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] out_re,
    input logic [DATA_WIDTH-1:0] out_im
);

    localparam logic [3:0] MAX_IN_FLIGHT = 4'd5;

    logic       parity_reg;
    logic [3:0] pending_reg;
    logic       in_acc;
    logic       out_acc;
    logic       owe;

    assign in_acc  = in_valid & in_ready;
    assign out_acc = out_valid & out_ready;
    assign owe     = in_acc & parity_reg;

    // results owed: one per second accepted word, minus those delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg  <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                parity_reg <= ~parity_reg;
            end
            pending_reg <= pending_reg + 4'(owe) - 4'(out_acc);
        end
    end

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im))
        else $error("result word changed while stalled");

    // input back-pressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // no result word without a second accepted input word behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 4'd0)
        else $error("result word delivered that no input word caused");

    // owed results never exceed the pipeline depth
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= MAX_IN_FLIGHT)
        else $error("more results in flight than pipeline stages");

endmodule

bind halfband_fir_decimate_by2_top hbd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_hbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_re    (out_re),
    .out_im    (out_im)
);

>>> dv/halfband_fir_decimate_by2_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// halfband_fir_decimate_by2_top_tb
// Self-checking bench for the 27-tap half-band decimator. A cycle-free model
// of the delay line and the symmetric pre-add sum predicts every second
// accepted word. Each result word is compared with the oldest prediction.
// Coefficient sets cover reset values, both extremes, a rounding-only set,
// random sets and writes to unused indexes. Both handshakes idle at random,
// and the output is held off for a long stretch to fill the pipeline.
// ----------------------------------------------------------------------------
module halfband_fir_decimate_by2_top_tb;
    import hbd_pkg::*;

    localparam int DW           = DATA_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;

    localparam longint ACC_HI = (longint'(1) << (DW - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    // first index past the coefficient registers; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_TAP_CENTRE + 1'b1;

    typedef logic signed [DW-1:0] smp_t;
    typedef smp_t line_t [NTAPS];

    typedef struct packed {
        smp_t re;
        smp_t im;
    } cplx_t;

    localparam smp_t SMP_HI = smp_t'(ACC_HI);
    localparam smp_t SMP_LO = smp_t'(ACC_LO);

    // dut ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    smp_t                 sample_re = '0;
    smp_t                 sample_im = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    smp_t                 out_re;
    smp_t                 out_im;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    // predictor state
    coef_t coefs [NCOEF] = COEF_RESET;
    line_t line_re;
    line_t line_im;
    bit    odd_phase;
    cplx_t pending_results [$];

    // stimulus and receiver control
    bit    send_steady;
    bit    rcv_steady;
    bit    hold_req;
    int    hold_left;
    int    run_left;
    smp_t  run_re;
    smp_t  run_im;

    // bookkeeping
    int    fail_count;
    int    words_in;
    int    words_out;
    int    coef_writes;
    int    stall_cycles;
    cplx_t got_word;
    cplx_t want_word;

    halfband_fir_decimate_by2_top #(
        .DATA_WIDTH (DW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_re    (out_re),
        .out_im    (out_im),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #3_000_000;
        $display("halfband_fir_decimate_by2_top regression: fail");
        $finish;
    end

    // symmetric half-band sum of one part, rounded half up and saturated
    function automatic smp_t fir_branch(input line_t dl);
        longint acc;
        longint rnd;
        int     k;
        acc = 0;
        for (k = 0; k < NPAIR; k++)
        begin
            acc += (longint'(dl[2*k]) + longint'(dl[NTAPS-1-2*k])) * longint'(coefs[k]);
        end
        acc += longint'(dl[CENTRE]) * longint'(coefs[SLOT_CENTRE]);
        rnd = (acc + 1) >>> 1;
        if (rnd > ACC_HI)
            rnd = ACC_HI;
        else if (rnd < ACC_LO)
            rnd = ACC_LO;
        return smp_t'(rnd);
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // result check, then delay line update and coefficient tracking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                words_out++;
                got_word = '{re: out_re, im: out_im};
                if (pending_results.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected word re %0d im %0d", out_re, out_im));
                end
                else
                begin
                    want_word = pending_results.pop_front();
                    if (got_word.re !== want_word.re || got_word.im !== want_word.im)
                        note_mismatch($sformatf("word %0d: expected re %0d im %0d, got re %0d im %0d",
                            words_out, want_word.re, want_word.im, got_word.re, got_word.im));
                end
            end
            if (in_valid && !in_ready)
                stall_cycles++;
            if (in_valid && in_ready)
            begin
                words_in++;
                for (int i = NTAPS - 1; i > 0; i--)
                begin
                    line_re[i] = line_re[i-1];
                    line_im[i] = line_im[i-1];
                end
                line_re[0] = sample_re;
                line_im[0] = sample_im;
                if (odd_phase)
                    pending_results.push_back('{re: fir_branch(line_re), im: fir_branch(line_im)});
                odd_phase = ~odd_phase;
            end
            if (cfg_wr_en)
            begin
                coef_writes++;
                if (cfg_index <= REG_TAP_CENTRE)
                    coefs[cfg_index] = coef_t'(cfg_data);
            end
        end
    end

    // receiver: random idling, steady stretches and a counted hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (rcv_steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= 8);
        end
    end

    // one word on the input channel, entered and left at a falling edge
    task automatic send_sample(input smp_t re, input smp_t im);
        if (!send_steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic smp_t pick_extreme();
        return $urandom_range(1) ? SMP_HI : SMP_LO;
    endfunction

    function automatic smp_t rand_sample();
        case ($urandom_range(7))
            0: return SMP_HI;
            1: return SMP_LO;
            2: return smp_t'(int'($urandom_range(32)) - 16);
            default: return smp_t'($urandom);
        endcase
    endfunction

    // random words, with runs of constant extremes to push the sum into saturation
    task automatic send_random(input int n);
        smp_t re;
        smp_t im;
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0 && $urandom_range(19) == 0)
            begin
                run_left = $urandom_range(40, 10);
                run_re   = pick_extreme();
                run_im   = pick_extreme();
            end
            if (run_left > 0)
            begin
                re = run_re;
                im = run_im;
                run_left--;
            end
            else
            begin
                re = rand_sample();
                im = rand_sample();
            end
            send_sample(re, im);
        end
    endtask

    // sender pause until every predicted word has come, then let the pipe settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_coefs(input coef_t val);
        for (int i = 0; i < NCOEF; i++)
            write_reg(REG_TAP_ZERO + CFG_IDX_W'(i), val);
    endtask

    // reset coefficients: impulse response, then field extremes
    task automatic test_impulse();
        send_sample(SMP_HI, SMP_LO);
        for (int i = 0; i < 13; i++)
            send_sample('0, '0);
        send_sample(SMP_HI, SMP_HI);
        send_sample(SMP_LO, SMP_LO);
        send_sample(SMP_HI, SMP_LO);
        send_sample(SMP_LO, SMP_HI);
        send_sample(smp_t'(1), smp_t'(-1));
        send_sample(smp_t'(16'h5555), smp_t'(16'hAAAA));
        send_sample(smp_t'(16'hAAAA), smp_t'(16'h5555));
        send_sample(smp_t'(-1), smp_t'(1));
        wait_drain();
    endtask

    // all coefficients at the positive, then the negative extreme
    task automatic test_coef_extremes();
        write_all_coefs(coef_t'(SMP_HI));
        send_random(60);
        wait_drain();
        write_all_coefs(coef_t'(SMP_LO));
        send_random(60);
        wait_drain();
    endtask

    // centre tap of one only, so each result is the halved sample rounded half up;
    // unused register indexes must leave the set alone
    task automatic test_rounding();
        write_all_coefs('0);
        write_reg(REG_TAP_CENTRE, coef_t'(1));
        for (int i = REG_SPARE_FIRST; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
        send_random(40);
        wait_drain();
    endtask

    // random coefficient sets, the first one with no idling on either side
    task automatic test_random_coefs();
        for (int r = 0; r < 3; r++)
        begin
            send_steady = (r == 0);
            rcv_steady  = (r == 0);
            for (int i = 0; i < NCOEF; i++)
                write_reg(REG_TAP_ZERO + CFG_IDX_W'(i), COEF_W'($urandom));
            send_random(50);
            wait_drain();
        end
        send_steady = 1'b0;
        rcv_steady  = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so in_ready must drop
    task automatic test_backpressure();
        hold_req    = 1'b1;
        send_steady = 1'b1;
        send_random(60);
        send_steady = 1'b0;
        wait_drain();
    endtask

    // back to the reset coefficient set by explicit writes
    task automatic test_reload_defaults();
        for (int i = 0; i < NCOEF; i++)
            write_reg(REG_TAP_ZERO + CFG_IDX_W'(i), COEF_RESET[i]);
        send_random(60);
        wait_drain();
    endtask

    initial
    begin
        line_re = '{default: '0};
        line_im = '{default: '0};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_impulse();
        test_coef_extremes();
        test_rounding();
        test_random_coefs();
        test_backpressure();
        test_reload_defaults();

        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d predicted words never came", pending_results.size()));

        $display("covered %0d input words, %0d result words, %0d register writes",
            words_in, words_out, coef_writes);
        $display("input stalled for %0d cycles, %0d mismatches", stall_cycles, fail_count);
        if (fail_count == 0)
            $display("halfband_fir_decimate_by2_top regression: pass");
        else
            $display("halfband_fir_decimate_by2_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
sv/hbd_pkg.sv
sv/hbd_coef_regs.sv
sv/hbd_delay_line.sv
sv/hbd_datapath.sv
sv/halfband_fir_decimate_by2_top.sv
sv/hbd_checker.sv
dv/halfband_fir_decimate_by2_top_tb.sv
